@@ hdl/setpoint_transition_drive_controller_assert.svh @@
// Assertion macros for the setpoint transition drive controller.
`ifndef SETPOINT_TRANSITION_DRIVE_CONTROLLER_ASSERT_SVH
`define SETPOINT_TRANSITION_DRIVE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define STDC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define STDC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/stdc_pkg.sv @@
// Shared types, levels and drive constants of the setpoint transition drive controller.
`default_nettype none

package stdc_pkg;

    localparam int STDC_STEP_COUNT_WIDTH = 10;
    localparam int STDC_TARGET_W         = 15;
    localparam int STDC_MEAS_W           = 16;
    localparam int STDC_DRIVE_W          = 12;
    localparam int STDC_CMP_W            = 18;

    localparam logic [STDC_TARGET_W-1:0] STDC_LVL_0   = 15'd0;
    localparam logic [STDC_TARGET_W-1:0] STDC_LVL_20  = 15'd2000;
    localparam logic [STDC_TARGET_W-1:0] STDC_LVL_60  = 15'd6000;
    localparam logic [STDC_TARGET_W-1:0] STDC_LVL_150 = 15'd15000;

    localparam int STDC_BOOST1_LAST = 2;
    localparam int STDC_BOOST2_LAST = 10;
    localparam int STDC_BOOST3_LAST = 17;
    localparam int STDC_SETTLE_END  = 50;
    localparam int STDC_DOWN_LAST   = 200;
    localparam int STDC_DOWN_SKIP   = 200;

    localparam logic signed [STDC_DRIVE_W-1:0] STDC_DRV_ZERO    = 12'sd0;
    localparam logic signed [STDC_DRIVE_W-1:0] STDC_DRV_BANG    = 12'sd6;
    localparam logic signed [STDC_DRIVE_W-1:0] STDC_DRV_BOOST1  = 12'sd830;
    localparam logic signed [STDC_DRIVE_W-1:0] STDC_DRV_BOOST2  = 12'sd1150;
    localparam logic signed [STDC_DRIVE_W-1:0] STDC_DRV_BOOST3  = 12'sd1160;
    localparam logic signed [STDC_DRIVE_W-1:0] STDC_DRV_DOWN    = -12'sd800;
    localparam logic signed [STDC_DRIVE_W-1:0] STDC_DRV_DROP    = -12'sd1200;
    localparam logic signed [STDC_DRIVE_W-1:0] STDC_DRV_PULL_HI = -12'sd1100;
    localparam logic signed [STDC_DRIVE_W-1:0] STDC_DRV_PULL_LO = -12'sd100;

    localparam logic signed [STDC_CMP_W-1:0] STDC_BAND_HI   = 18'sd50;
    localparam logic signed [STDC_CMP_W-1:0] STDC_BAND_MID  = 18'sd10;
    localparam logic signed [STDC_CMP_W-1:0] STDC_BAND_LO   = 18'sd5;
    localparam logic signed [STDC_CMP_W-1:0] STDC_NEAR_ZERO = 18'sd10;

    typedef enum logic [2:0] {
        CASE_DEFAULT = 3'd0,
        CASE_0_20    = 3'd1,
        CASE_20_60   = 3'd2,
        CASE_60_150  = 3'd3,
        CASE_150_60  = 3'd4,
        CASE_60_20   = 3'd5,
        CASE_20_0    = 3'd6
    } stdc_case_t;

    typedef struct packed {
        logic [STDC_TARGET_W-1:0] last_target;
        stdc_case_t               active_case;
    } stdc_ctl_t;

    function automatic stdc_case_t stdc_classify(
        input logic [STDC_TARGET_W-1:0] prev,
        input logic [STDC_TARGET_W-1:0] tgt
    );
        stdc_case_t c;
        c = CASE_DEFAULT;
        if (prev == STDC_LVL_0 && tgt == STDC_LVL_20) begin
            c = CASE_0_20;
        end else if (prev == STDC_LVL_20 && tgt == STDC_LVL_60) begin
            c = CASE_20_60;
        end else if (prev == STDC_LVL_60 && tgt == STDC_LVL_150) begin
            c = CASE_60_150;
        end else if (prev == STDC_LVL_150 && tgt == STDC_LVL_60) begin
            c = CASE_150_60;
        end else if (prev == STDC_LVL_60 && tgt == STDC_LVL_20) begin
            c = CASE_60_20;
        end else if (prev == STDC_LVL_20 && tgt == STDC_LVL_0) begin
            c = CASE_20_0;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/setpoint_transition_drive_controller.sv @@
// Top level of the setpoint transition drive controller: word registers, state and handshakes.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------------------------
//   s_      | in        | s_valid, s_ready, s_req_type, s_target_centivolts,
//           |           | s_measured_centivolts
//   m_      | out       | m_valid, m_ready, m_drive
//
// One word per cycle while m_ready stays high; a word goes through the input register,
// then the drive law into the result register (which also updates the stored state) to m_.
// Synchronous active-low reset clears the stored setpoint, case and step count.
// A stall on m_ holds the result register and then the input register; s_ready drops
// only when both are full and m_ready is low.
`default_nettype none

module setpoint_transition_drive_controller
    import stdc_pkg::*;
#(
    parameter int STEP_COUNT_WIDTH = STDC_STEP_COUNT_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_req_type,
    input  wire logic        [STDC_TARGET_W-1:0] s_target_centivolts,
    input  wire logic signed [STDC_MEAS_W-1:0]  s_measured_centivolts,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed      [STDC_DRIVE_W-1:0] m_drive
);

    logic                               in_valid_reg;
    logic                               in_valid_next;
    logic                               in_req_reg;
    logic        [STDC_TARGET_W-1:0]    in_target_reg;
    logic signed [STDC_MEAS_W-1:0]      in_meas_reg;

    stdc_ctl_t                          ctl_reg;
    stdc_ctl_t                          ctl_next;
    logic        [STEP_COUNT_WIDTH-1:0] count_reg;
    logic        [STEP_COUNT_WIDTH-1:0] count_next;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [STDC_DRIVE_W-1:0]     out_drive_reg;
    logic signed [STDC_DRIVE_W-1:0]     law_drive;

    logic                               out_free;
    logic                               advance;
    logic                               s_fire;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_drive  = out_drive_reg;

    stdc_law #(
        .STEP_COUNT_WIDTH(STEP_COUNT_WIDTH)
    ) u_law (
        .req_type  (in_req_reg),
        .target    (in_target_reg),
        .measured  (in_meas_reg),
        .ctl_cur   (ctl_reg),
        .count_cur (count_reg),
        .ctl_next  (ctl_next),
        .count_next(count_next),
        .drive     (law_drive)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctl_reg       <= '{last_target: '0, active_case: CASE_DEFAULT};
            count_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                ctl_reg   <= ctl_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg    <= s_req_type;
            in_target_reg <= s_target_centivolts;
            in_meas_reg   <= s_measured_centivolts;
        end
        if (advance) begin
            out_drive_reg <= law_drive;
        end
    end

`include "setpoint_transition_drive_controller_assert.svh"

    `STDC_ASSERT_NEXT(a_req_clears_state, advance && in_req_reg,
        ctl_reg.last_target == '0 && count_reg == '0, "reset request left state behind")

    `STDC_ASSERT_NEXT(a_req_gives_zero, advance && in_req_reg,
        m_valid && m_drive == STDC_DRV_ZERO, "reset request gave nonzero drive")

    `STDC_ASSERT_NEXT(a_state_holds_idle, !advance,
        $stable(count_reg) && $stable(ctl_reg), "state moved without a word")

    `STDC_ASSERT_NEXT(a_drop_case_drive,
        advance && !in_req_reg && ctl_next.active_case == CASE_20_0
            && in_target_reg >= 15'd10,
        m_drive == STDC_DRV_DROP, "drop case gave wrong drive")

endmodule

`default_nettype wire

@@ hdl/stdc_law.sv @@
// Drive law: case selection, step counter update and drive value for one word.
`default_nettype none

module stdc_law
    import stdc_pkg::*;
#(
    parameter int STEP_COUNT_WIDTH = STDC_STEP_COUNT_WIDTH
) (
    input  wire logic                               req_type,
    input  wire logic        [STDC_TARGET_W-1:0]    target,
    input  wire logic signed [STDC_MEAS_W-1:0]      measured,
    input  wire stdc_ctl_t                          ctl_cur,
    input  wire logic        [STEP_COUNT_WIDTH-1:0] count_cur,
    output stdc_ctl_t                               ctl_next,
    output logic             [STEP_COUNT_WIDTH-1:0] count_next,
    output logic signed      [STDC_DRIVE_W-1:0]     drive
);

    localparam logic [STEP_COUNT_WIDTH-1:0] CNT_MAX     = '1;
    localparam logic [STEP_COUNT_WIDTH-1:0] CNT_B1_LAST =
        STEP_COUNT_WIDTH'(STDC_BOOST1_LAST);
    localparam logic [STEP_COUNT_WIDTH-1:0] CNT_B2_LAST =
        STEP_COUNT_WIDTH'(STDC_BOOST2_LAST);
    localparam logic [STEP_COUNT_WIDTH-1:0] CNT_B3_LAST =
        STEP_COUNT_WIDTH'(STDC_BOOST3_LAST);
    localparam logic [STEP_COUNT_WIDTH-1:0] CNT_SETTLE  =
        STEP_COUNT_WIDTH'(STDC_SETTLE_END);
    localparam logic [STEP_COUNT_WIDTH-1:0] CNT_DN_LAST =
        STEP_COUNT_WIDTH'(STDC_DOWN_LAST);
    localparam logic [STEP_COUNT_WIDTH:0]   CNT_ONE     = (STEP_COUNT_WIDTH+1)'(1);
    localparam logic [STEP_COUNT_WIDTH:0]   CNT_SKIP    =
        (STEP_COUNT_WIDTH+1)'(STDC_DOWN_SKIP);

    logic                               changed;
    stdc_case_t                         case_eff;
    logic        [STEP_COUNT_WIDTH-1:0] cnt_eff;
    logic        [STEP_COUNT_WIDTH:0]   sum_one;
    logic        [STEP_COUNT_WIDTH:0]   sum_skip;
    logic        [STEP_COUNT_WIDTH-1:0] cnt_inc;
    logic        [STEP_COUNT_WIDTH-1:0] cnt_skip;
    logic signed [STDC_CMP_W-1:0]       t_ext;
    logic signed [STDC_CMP_W-1:0]       m_ext;
    logic                               below;
    logic signed [STDC_DRIVE_W-1:0]     bang_drv;
    logic signed [STDC_DRIVE_W-1:0]     law_drv;
    logic        [STEP_COUNT_WIDTH-1:0] law_cnt;

    always_comb begin
        changed  = (target != ctl_cur.last_target);
        case_eff = changed ? stdc_classify(ctl_cur.last_target, target) : ctl_cur.active_case;
        cnt_eff  = changed ? '0 : count_cur;

        sum_one  = {1'b0, cnt_eff} + CNT_ONE;
        sum_skip = {1'b0, cnt_eff} + CNT_SKIP;
        cnt_inc  = sum_one[STEP_COUNT_WIDTH] ? CNT_MAX : sum_one[STEP_COUNT_WIDTH-1:0];
        cnt_skip = sum_skip[STEP_COUNT_WIDTH] ? CNT_MAX : sum_skip[STEP_COUNT_WIDTH-1:0];

        t_ext    = signed'({{(STDC_CMP_W-STDC_TARGET_W){1'b0}}, target});
        m_ext    = signed'({{(STDC_CMP_W-STDC_MEAS_W){measured[STDC_MEAS_W-1]}}, measured});
        below    = (m_ext < t_ext - STDC_BAND_LO);
        bang_drv = below ? STDC_DRV_BANG : STDC_DRV_ZERO;

        law_drv = STDC_DRV_ZERO;
        law_cnt = cnt_eff;
        case (case_eff)
            CASE_0_20: begin
                if (cnt_eff <= CNT_B1_LAST) begin
                    law_drv = STDC_DRV_BOOST1;
                    law_cnt = cnt_inc;
                end else if (cnt_eff < CNT_SETTLE) begin
                    law_cnt = cnt_inc;
                end else begin
                    law_drv = bang_drv;
                end
            end
            CASE_20_60: begin
                if (cnt_eff <= CNT_B2_LAST) begin
                    law_drv = STDC_DRV_BOOST2;
                    law_cnt = cnt_inc;
                end else if (cnt_eff < CNT_SETTLE) begin
                    law_cnt = cnt_inc;
                end else begin
                    law_drv = bang_drv;
                end
            end
            CASE_60_150: begin
                if (cnt_eff <= CNT_B3_LAST) begin
                    law_drv = STDC_DRV_BOOST3;
                    law_cnt = cnt_inc;
                end else begin
                    law_drv = bang_drv;
                end
            end
            CASE_150_60, CASE_60_20: begin
                if (cnt_eff <= CNT_DN_LAST && m_ext > t_ext) begin
                    law_drv = STDC_DRV_DOWN;
                    law_cnt = cnt_inc;
                end else begin
                    law_drv = bang_drv;
                    law_cnt = cnt_skip;
                end
            end
            CASE_20_0: begin
                law_drv = STDC_DRV_DROP;
            end
            default: begin
                if (m_ext > t_ext + STDC_BAND_HI) begin
                    law_drv = STDC_DRV_PULL_HI;
                end else if (m_ext > t_ext + STDC_BAND_MID) begin
                    law_drv = STDC_DRV_PULL_LO;
                end else begin
                    law_drv = bang_drv;
                end
            end
        endcase

        if (t_ext < STDC_NEAR_ZERO && m_ext < STDC_NEAR_ZERO) begin
            law_drv = STDC_DRV_ZERO;
        end

        if (req_type) begin
            ctl_next.last_target = '0;
            ctl_next.active_case = ctl_cur.active_case;
            count_next           = '0;
            drive                = STDC_DRV_ZERO;
        end else begin
            ctl_next.last_target = target;
            ctl_next.active_case = case_eff;
            count_next           = law_cnt;
            drive                = law_drv;
        end
    end

endmodule

`default_nettype wire
